FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define PTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ptd_pkg.sv
// Shared constants, region codes and latency helper for the point-triangle distance block.
package ptd_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int DIST_WIDTH      = 32;
    localparam int MUL_CHUNK_LOG   = 5;
    localparam int MUL_CHUNK       = 1 << MUL_CHUNK_LOG;

    typedef enum logic [2:0] {
        RG_VERT_A  = 3'd0,
        RG_VERT_B  = 3'd1,
        RG_VERT_C  = 3'd2,
        RG_EDGE_AB = 3'd3,
        RG_EDGE_AC = 3'd4,
        RG_EDGE_BC = 3'd5,
        RG_FACE    = 3'd6,
        RG_DEGEN   = 3'd7
    } t_region;

    function automatic int mul_lat(input int aw, input int bw);
        int na;
        int nb;
        na = (aw + MUL_CHUNK - 1) >> MUL_CHUNK_LOG;
        nb = (bw + MUL_CHUNK - 1) >> MUL_CHUNK_LOG;
        return na * nb + 3;
    endfunction

endpackage

FILE: rtl/point_triangle_distance.sv
// Top level of the point-triangle distance pipeline.
//
// Input channel: i_in_valid / o_in_ready carry one word holding a query point and
// three triangle vertices, twelve signed Q16.16 coordinates of COORD_WIDTH bits.
// Output channel: o_out_valid / i_out_ready carry one word per input word: the
// floor of the exact Euclidean distance as unsigned Q16.16 (saturated at all
// ones) and the region code of the nearest feature.
// Pipeline: two chunked multiplier banks (12 and 19 stages at COORD_WIDTH 32,
// one 32x32 partial product per stage), the 33-stage square-root pipeline,
// and seven stages of differences, dot products and region selection.
// Throughput: one word per cycle while the receiver does not stall; words in flight are independent.
// Reset: i_rst_n, synchronous and active low, drops every word in flight.
// Stall: when the receiver holds i_out_ready low, one more result goes into a
// skid register; after that o_in_ready drops and the whole pipeline holds.
module point_triangle_distance import ptd_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    input  logic signed [COORD_WIDTH-1:0] i_vert_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert_a_z,
    input  logic signed [COORD_WIDTH-1:0] i_vert_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert_b_z,
    input  logic signed [COORD_WIDTH-1:0] i_vert_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert_c_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert_c_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [DIST_WIDTH-1:0]         o_distance,
    output logic [2:0]                    o_region
);

    localparam int CW  = COORD_WIDTH;
    localparam int DFW = CW + 1;
    localparam int PRW = 2 * CW + 2;
    localparam int DW  = 2 * CW + 4;
    localparam int VW  = 2 * DW + 1;
    localparam int FW  = VW + 2;
    localparam int XW  = 3 * CW + 6;
    localparam int NW  = 2 * XW;
    localparam int LW  = 2 * CW + 6;
    localparam int M1L = mul_lat(DW, DW);
    localparam int M2L = mul_lat(XW, XW);

    logic c_en;

    // stage 1: edge and offset vectors
    logic signed [CW-1:0]  c_pin [3];
    logic signed [CW-1:0]  c_ain [3];
    logic signed [CW-1:0]  c_bin [3];
    logic signed [CW-1:0]  c_cin [3];
    logic signed [DFW-1:0] r1_ab [3];
    logic signed [DFW-1:0] r1_ac [3];
    logic signed [DFW-1:0] r1_ap [3];
    logic signed [DFW-1:0] r1_bp [3];
    logic signed [DFW-1:0] r1_cp [3];
    logic                  r1_v;

    // stage 2: coordinate products
    logic signed [DFW-1:0] c_u   [33];
    logic signed [DFW-1:0] c_w   [33];
    logic signed [PRW-1:0] r2_pr [33];
    logic signed [DFW-1:0] r2_ap [3];
    logic                  r2_v;

    // stage 3: dot products and normal
    logic signed [DW-1:0]  r3_d  [9];
    logic signed [DW-1:0]  r3_n  [3];
    logic signed [DW-1:0]  r3_ap [3];
    logic                  r3_v;

    // first multiplier bank
    logic signed [DW-1:0]   c_ma   [9];
    logic signed [DW-1:0]   c_mb   [9];
    logic signed [2*DW-1:0] m1_p   [9];
    logic [9*DW-1:0]        c_side1;
    logic [9*DW-1:0]        m1_side;
    logic                   m1_v;

    // stage 5: barycentric numerators and face projection
    logic signed [VW-1:0]  r5_va;
    logic signed [VW-1:0]  r5_vb;
    logic signed [VW-1:0]  r5_vc;
    logic signed [XW-1:0]  r5_s;
    logic signed [DW-1:0]  r5_d [9];
    logic                  r5_v;

    // stage 6: face denominator and edge terms
    logic signed [FW-1:0]  r6_fden;
    logic signed [LW-1:0]  r6_e1;
    logic signed [LW-1:0]  r6_e2;
    logic signed [LW-1:0]  r6_lab;
    logic signed [LW-1:0]  r6_lac;
    logic signed [LW-1:0]  r6_lbc;
    logic signed [VW-1:0]  r6_va;
    logic signed [VW-1:0]  r6_vb;
    logic signed [VW-1:0]  r6_vc;
    logic signed [XW-1:0]  r6_s;
    logic signed [DW-1:0]  r6_d [9];
    logic                  r6_v;

    // stage 7: region selection
    logic                  c_le_d1, c_le_d2, c_le_d3, c_le_d6;
    logic                  c_ge_d1, c_ge_d2, c_ge_d3, c_ge_d6;
    logic                  c_le_va, c_le_vb, c_le_vc, c_le_fd;
    logic                  c_le_e1, c_le_e2, c_ge_e1, c_ge_e2;
    logic                  c_edge;
    logic signed [DW-1:0]  c_s2;
    logic signed [LW-1:0]  c_proj;
    logic signed [LW-1:0]  c_len;
    logic signed [XW-1:0]  c_x;
    logic signed [XW-1:0]  c_y;
    logic signed [XW-1:0]  c_z;
    logic [FW-1:0]         c_den;
    t_region               c_reg;
    logic signed [XW-1:0]  r7_x;
    logic signed [XW-1:0]  r7_y;
    logic signed [XW-1:0]  r7_z;
    logic [FW-1:0]         r7_den;
    t_region               r7_reg;
    logic                  r7_v;

    // second multiplier bank
    logic signed [NW-1:0]  m2_xy;
    logic signed [NW-1:0]  m2_zz;
    logic [FW+2:0]         m2_side;
    logic                  m2_v;

    // stage 9: squared-distance numerator
    logic [NW-1:0]         r9_num;
    logic [FW-1:0]         r9_den;
    t_region               r9_reg;
    logic                  r9_v;

    // root and output skid
    logic                  rt_v;
    logic [DIST_WIDTH-1:0] rt_dist;
    t_region               rt_reg;
    logic                  c_take;
    logic                  c_arrive;
    logic                  r_out_valid, n_out_valid;
    logic [DIST_WIDTH-1:0] r_out_dist,  n_out_dist;
    t_region               r_out_reg,   n_out_reg;
    logic                  r_skid_valid, n_skid_valid;
    logic [DIST_WIDTH-1:0] r_skid_dist,  n_skid_dist;
    t_region               r_skid_reg,   n_skid_reg;

    assign c_en       = !r_skid_valid;
    assign o_in_ready = c_en;

    always_comb begin
        c_pin[0] = i_point_x;  c_pin[1] = i_point_y;  c_pin[2] = i_point_z;
        c_ain[0] = i_vert_a_x; c_ain[1] = i_vert_a_y; c_ain[2] = i_vert_a_z;
        c_bin[0] = i_vert_b_x; c_bin[1] = i_vert_b_y; c_bin[2] = i_vert_b_z;
        c_cin[0] = i_vert_c_x; c_cin[1] = i_vert_c_y; c_cin[2] = i_vert_c_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (c_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r5_v <= m1_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r9_v <= m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_ab[k] <= DFW'(c_bin[k]) - DFW'(c_ain[k]);
                r1_ac[k] <= DFW'(c_cin[k]) - DFW'(c_ain[k]);
                r1_ap[k] <= DFW'(c_pin[k]) - DFW'(c_ain[k]);
                r1_bp[k] <= DFW'(c_pin[k]) - DFW'(c_bin[k]);
                r1_cp[k] <= DFW'(c_pin[k]) - DFW'(c_cin[k]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_u[k]      = r1_ab[k]; c_w[k]      = r1_ap[k];
            c_u[3 + k]  = r1_ac[k]; c_w[3 + k]  = r1_ap[k];
            c_u[6 + k]  = r1_ab[k]; c_w[6 + k]  = r1_bp[k];
            c_u[9 + k]  = r1_ac[k]; c_w[9 + k]  = r1_bp[k];
            c_u[12 + k] = r1_ab[k]; c_w[12 + k] = r1_cp[k];
            c_u[15 + k] = r1_ac[k]; c_w[15 + k] = r1_cp[k];
            c_u[18 + k] = r1_ap[k]; c_w[18 + k] = r1_ap[k];
            c_u[21 + k] = r1_bp[k]; c_w[21 + k] = r1_bp[k];
            c_u[24 + k] = r1_cp[k]; c_w[24 + k] = r1_cp[k];
        end
        c_u[27] = r1_ab[1]; c_w[27] = r1_ac[2];
        c_u[28] = r1_ab[2]; c_w[28] = r1_ac[1];
        c_u[29] = r1_ab[2]; c_w[29] = r1_ac[0];
        c_u[30] = r1_ab[0]; c_w[30] = r1_ac[2];
        c_u[31] = r1_ab[0]; c_w[31] = r1_ac[1];
        c_u[32] = r1_ab[1]; c_w[32] = r1_ac[0];
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            for (int i = 0; i < 33; i++) begin
                r2_pr[i] <= PRW'(c_u[i]) * PRW'(c_w[i]);
            end
            for (int k = 0; k < 3; k++) begin
                r2_ap[k] <= r1_ap[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            for (int q = 0; q < 9; q++) begin
                r3_d[q] <= DW'(r2_pr[3*q]) + DW'(r2_pr[3*q + 1]) + DW'(r2_pr[3*q + 2]);
            end
            r3_n[0] <= DW'(r2_pr[27]) - DW'(r2_pr[28]);
            r3_n[1] <= DW'(r2_pr[29]) - DW'(r2_pr[30]);
            r3_n[2] <= DW'(r2_pr[31]) - DW'(r2_pr[32]);
            for (int k = 0; k < 3; k++) begin
                r3_ap[k] <= DW'(r2_ap[k]);
            end
        end
    end

    always_comb begin
        c_ma[0] = r3_d[0]; c_mb[0] = r3_d[3];
        c_ma[1] = r3_d[2]; c_mb[1] = r3_d[1];
        c_ma[2] = r3_d[4]; c_mb[2] = r3_d[1];
        c_ma[3] = r3_d[0]; c_mb[3] = r3_d[5];
        c_ma[4] = r3_d[2]; c_mb[4] = r3_d[5];
        c_ma[5] = r3_d[4]; c_mb[5] = r3_d[3];
        for (int k = 0; k < 3; k++) begin
            c_ma[6 + k] = r3_n[k];
            c_mb[6 + k] = r3_ap[k];
        end
        for (int q = 0; q < 9; q++) begin
            c_side1[q*DW +: DW] = r3_d[q];
        end
    end

    for (genvar gm = 0; gm < 9; gm++) begin : g_m1
        ptd_mul #(
            .AW(DW),
            .BW(DW)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (c_en),
            .i_a   (c_ma[gm]),
            .i_b   (c_mb[gm]),
            .o_p   (m1_p[gm])
        );
    end

    ptd_delay #(
        .DW    (9 * DW),
        .DEPTH (M1L)
    ) u_side1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (r3_v),
        .i_data  (c_side1),
        .o_valid (m1_v),
        .o_data  (m1_side)
    );

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r5_vc <= VW'(m1_p[0]) - VW'(m1_p[1]);
            r5_vb <= VW'(m1_p[2]) - VW'(m1_p[3]);
            r5_va <= VW'(m1_p[4]) - VW'(m1_p[5]);
            r5_s  <= XW'(m1_p[6]) + XW'(m1_p[7]) + XW'(m1_p[8]);
            for (int q = 0; q < 9; q++) begin
                r5_d[q] <= $signed(m1_side[q*DW +: DW]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r6_fden <= FW'(r5_va) + FW'(r5_vb) + FW'(r5_vc);
            r6_e1   <= LW'(r5_d[3]) - LW'(r5_d[2]);
            r6_e2   <= LW'(r5_d[4]) - LW'(r5_d[5]);
            r6_lab  <= LW'(r5_d[0]) - LW'(r5_d[2]);
            r6_lac  <= LW'(r5_d[1]) - LW'(r5_d[5]);
            r6_lbc  <= LW'(r5_d[3]) - LW'(r5_d[2]) + LW'(r5_d[4]) - LW'(r5_d[5]);
            r6_va   <= r5_va;
            r6_vb   <= r5_vb;
            r6_vc   <= r5_vc;
            r6_s    <= r5_s;
            r6_d    <= r5_d;
        end
    end

    always_comb begin
        c_le_d1 = r6_d[0][DW-1] || (r6_d[0] == '0);
        c_le_d2 = r6_d[1][DW-1] || (r6_d[1] == '0);
        c_le_d3 = r6_d[2][DW-1] || (r6_d[2] == '0);
        c_le_d6 = r6_d[5][DW-1] || (r6_d[5] == '0);
        c_ge_d1 = !r6_d[0][DW-1];
        c_ge_d2 = !r6_d[1][DW-1];
        c_ge_d3 = !r6_d[2][DW-1];
        c_ge_d6 = !r6_d[5][DW-1];
        c_le_va = r6_va[VW-1] || (r6_va == '0);
        c_le_vb = r6_vb[VW-1] || (r6_vb == '0);
        c_le_vc = r6_vc[VW-1] || (r6_vc == '0);
        c_le_fd = r6_fden[FW-1] || (r6_fden == '0);
        c_le_e1 = r6_e1[LW-1] || (r6_e1 == '0);
        c_le_e2 = r6_e2[LW-1] || (r6_e2 == '0);
        c_ge_e1 = !r6_e1[LW-1];
        c_ge_e2 = !r6_e2[LW-1];

        c_x    = XW'(r6_d[6]);
        c_y    = XW'(1);
        c_z    = '0;
        c_den  = FW'(1);
        c_reg  = RG_DEGEN;
        c_edge = 1'b0;
        c_s2   = r6_d[6];
        c_proj = '0;
        c_len  = '0;

        if (c_le_d1 && c_le_d2) begin
            c_reg = RG_VERT_A;
        end else if (c_ge_d3 && c_le_e1) begin
            c_reg = RG_VERT_B;
            c_x   = XW'(r6_d[7]);
        end else if (c_ge_d6 && c_le_e2) begin
            c_reg = RG_VERT_C;
            c_x   = XW'(r6_d[8]);
        end else if (c_le_vc && c_ge_d1 && c_le_d3) begin
            c_reg  = RG_EDGE_AB;
            c_edge = 1'b1;
            c_proj = LW'(r6_d[0]);
            c_len  = r6_lab;
        end else if (c_le_vb && c_ge_d2 && c_le_d6) begin
            c_reg  = RG_EDGE_AC;
            c_edge = 1'b1;
            c_proj = LW'(r6_d[1]);
            c_len  = r6_lac;
        end else if (c_le_va && c_ge_e1 && c_ge_e2) begin
            c_reg  = RG_EDGE_BC;
            c_edge = 1'b1;
            c_s2   = r6_d[7];
            c_proj = r6_e1;
            c_len  = r6_lbc;
        end else if (!c_le_fd) begin
            c_reg = RG_FACE;
            c_x   = r6_s;
            c_y   = r6_s;
            c_den = FW'(r6_fden);
        end

        if (c_edge) begin
            c_x = XW'(c_s2);
            if (c_len != '0) begin
                c_y   = XW'(c_len);
                c_z   = XW'(c_proj);
                c_den = FW'(c_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r7_x   <= c_x;
            r7_y   <= c_y;
            r7_z   <= c_z;
            r7_den <= c_den;
            r7_reg <= c_reg;
        end
    end

    ptd_mul #(
        .AW(XW),
        .BW(XW)
    ) u_mul_xy (
        .i_clk (i_clk),
        .i_en  (c_en),
        .i_a   (r7_x),
        .i_b   (r7_y),
        .o_p   (m2_xy)
    );

    ptd_mul #(
        .AW(XW),
        .BW(XW)
    ) u_mul_zz (
        .i_clk (i_clk),
        .i_en  (c_en),
        .i_a   (r7_z),
        .i_b   (r7_z),
        .o_p   (m2_zz)
    );

    ptd_delay #(
        .DW    (FW + 3),
        .DEPTH (M2L)
    ) u_side2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (r7_v),
        .i_data  ({r7_den, r7_reg}),
        .o_valid (m2_v),
        .o_data  (m2_side)
    );

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r9_num <= NW'(m2_xy - m2_zz);
            r9_den <= m2_side[FW+2:3];
            r9_reg <= t_region'(m2_side[2:0]);
        end
    end

    ptd_root #(
        .NW(NW),
        .FW(FW)
    ) u_root (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (c_en),
        .i_valid  (r9_v),
        .i_num    (r9_num),
        .i_den    (r9_den),
        .i_region (r9_reg),
        .o_valid  (rt_v),
        .o_dist   (rt_dist),
        .o_region (rt_reg)
    );

    always_comb begin
        c_take       = r_out_valid && i_out_ready;
        c_arrive     = c_en && rt_v;
        n_out_valid  = r_out_valid;
        n_out_dist   = r_out_dist;
        n_out_reg    = r_out_reg;
        n_skid_valid = r_skid_valid;
        n_skid_dist  = r_skid_dist;
        n_skid_reg   = r_skid_reg;
        if (c_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_dist   = r_skid_dist;
                n_out_reg    = r_skid_reg;
                n_skid_valid = 1'b0;
            end else if (c_arrive) begin
                n_out_valid = 1'b1;
                n_out_dist  = rt_dist;
                n_out_reg   = rt_reg;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (c_arrive) begin
            n_skid_valid = 1'b1;
            n_skid_dist  = rt_dist;
            n_skid_reg   = rt_reg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_dist  <= n_out_dist;
        r_out_reg   <= n_out_reg;
        r_skid_dist <= n_skid_dist;
        r_skid_reg  <= n_skid_reg;
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_out_dist;
    assign o_region    = r_out_reg;

endmodule

FILE: rtl/ptd_mul.sv
// Pipelined signed multiplier, one chunk-pair partial product per stage.
module ptd_mul import ptd_pkg::*; #(
    parameter int AW = 64,
    parameter int BW = 64
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int CH = MUL_CHUNK;
    localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NP = NA * NB;
    localparam int AP = NA * CH;
    localparam int BP = NB * CH;
    localparam int XP = AP + BP;
    localparam int PW = AW + BW;
    localparam int SHL = ((NP - 1) / NB + (NP - 1) % NB) * CH;

    logic [AW-1:0]   c_aa;
    logic [BW-1:0]   c_bb;
    logic [AP-1:0]   r_ma   [0:NP-1];
    logic [BP-1:0]   r_mb   [0:NP-1];
    logic            r_neg  [0:NP+1];
    logic [2*CH-1:0] r_pp   [1:NP];
    logic [PW-1:0]   r_acc  [1:NP];
    logic [PW-1:0]   r_sum;
    logic [PW-1:0]   r_p;
    logic [XP-1:0]   c_last;

    always_comb begin
        c_aa   = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
        c_bb   = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);
        c_last = XP'(r_pp[NP]) << SHL;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma[0]  <= AP'(c_aa);
            r_mb[0]  <= BP'(c_bb);
            r_neg[0] <= i_a[AW-1] ^ i_b[BW-1];
        end
    end

    for (genvar g = 0; g < NP; g++) begin : g_stage
        localparam int CI = g / NB;
        localparam int CJ = g % NB;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pp[g+1]  <= r_ma[g][CI*CH +: CH] * r_mb[g][CJ*CH +: CH];
                r_neg[g+1] <= r_neg[g];
            end
        end

        if (g + 1 < NP) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ma[g+1] <= r_ma[g];
                    r_mb[g+1] <= r_mb[g];
                end
            end
        end

        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_acc[1] <= '0;
                end
            end
        end else begin : g_accum
            localparam int SHP = ((g - 1) / NB + (g - 1) % NB) * CH;
            logic [XP-1:0] c_sh;
            assign c_sh = XP'(r_pp[g]) << SHP;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_acc[g+1] <= r_acc[g] + c_sh[PW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum       <= r_acc[NP] + c_last[PW-1:0];
            r_neg[NP+1] <= r_neg[NP];
            r_p         <= r_neg[NP+1] ? PW'(-r_sum) : r_sum;
        end
    end

    assign o_p = $signed(r_p);

endmodule

FILE: rtl/ptd_delay.sv
// Delay line that carries a valid bit and its side data alongside a multiplier bank.
module ptd_delay import ptd_pkg::*; #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);

    logic          r_v [0:DEPTH-1];
    logic [DW-1:0] r_d [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_data;
        end
    end

    for (genvar g = 1; g < DEPTH; g++) begin : g_tap
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= r_v[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[g] <= r_d[g-1];
            end
        end
    end

    assign o_valid = r_v[DEPTH-1];
    assign o_data  = r_d[DEPTH-1];

endmodule

FILE: rtl/ptd_root.sv
// Pipelined floor square root of a ratio, one result bit per stage, shift and add only.
module ptd_root import ptd_pkg::*; #(
    parameter int NW = 204,
    parameter int FW = 139
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [NW-1:0]         i_num,
    input  logic [FW-1:0]         i_den,
    input  t_region               i_region,
    output logic                  o_valid,
    output logic [DIST_WIDTH-1:0] o_dist,
    output t_region               o_region
);

    localparam int RW = ((NW > FW + 65) ? NW : FW + 65) + 1;
    localparam int NS = DIST_WIDTH;

    logic [RW-1:0]         r_r   [0:NS];
    logic [RW-1:0]         r_y   [0:NS];
    logic [FW-1:0]         r_den [0:NS];
    logic [DIST_WIDTH-1:0] r_d   [0:NS];
    t_region               r_reg [0:NS];
    logic                  r_v   [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]   <= RW'(i_num);
            r_y[0]   <= '0;
            r_den[0] <= i_den;
            r_d[0]   <= '0;
            r_reg[0] <= i_region;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_bit
        localparam int B = DIST_WIDTH - 1 - k;
        logic [RW-1:0] c_t;
        logic          c_fit;

        always_comb begin
            c_t   = (r_y[k] << (B + 1)) + (RW'(r_den[k]) << (2 * B));
            c_fit = (c_t <= r_r[k]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k+1] <= r_den[k];
                r_reg[k+1] <= r_reg[k];
                if (c_fit) begin
                    r_r[k+1] <= r_r[k] - c_t;
                    r_y[k+1] <= r_y[k] + (RW'(r_den[k]) << B);
                    r_d[k+1] <= r_d[k] | (DIST_WIDTH'(1) << B);
                end else begin
                    r_r[k+1] <= r_r[k];
                    r_y[k+1] <= r_y[k];
                    r_d[k+1] <= r_d[k];
                end
            end
        end
    end

    assign o_valid  = r_v[NS];
    assign o_dist   = r_d[NS];
    assign o_region = r_reg[NS];

endmodule

FILE: rtl/ptd_checker.sv
// Port-level checks for the point-triangle distance block, bound to the top level.
`include "assert_macros.svh"

module ptd_checker import ptd_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [DIST_WIDTH-1:0] o_distance,
    input logic [2:0]            o_region
);

    `PTD_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_distance) && $stable(o_region),
        "output word changed while stalled")

    `PTD_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !o_out_valid,
        "output valid after reset")

    `PTD_ASSERT(a_ready_back, i_clk, i_rst_n,
        o_out_valid && i_out_ready |=> o_in_ready,
        "input not ready after an output word was taken")

    `PTD_ASSERT(a_stall_full, i_clk, i_rst_n,
        !o_in_ready |-> o_out_valid,
        "input stalled with no output word pending")

endmodule

bind point_triangle_distance ptd_checker u_ptd_checker (.*);

FILE: tb/sv/tb_point_triangle_distance.sv
// Testbench for point_triangle_distance: region and exact-distance checks against a local predictor.
module tb_point_triangle_distance import ptd_pkg::*; ();

    typedef logic signed [383:0] t_wide;
    typedef logic signed [31:0] t_crd;
    typedef struct {
        t_wide x;
        t_wide y;
        t_wide z;
    } t_vec;

    localparam int   CYCLE_LIMIT = 400000;
    localparam int   LATENCY     = 72;
    localparam t_crd ONE         = 32'sh0001_0000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    t_crd           crd [12];
    logic           o_out_valid;
    logic           i_out_ready;
    logic [31:0]    o_distance;
    logic [2:0]     o_region;

    logic [31:0]    exp_dist_q [$];
    t_region        exp_region_q [$];
    int             errors;
    int             words_sent;
    int             words_checked;
    int             cycles;
    bit             no_idle;
    int             region_seen [8];

    point_triangle_distance u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_point_x   (crd[0]),
        .i_point_y   (crd[1]),
        .i_point_z   (crd[2]),
        .i_vert_a_x  (crd[3]),
        .i_vert_a_y  (crd[4]),
        .i_vert_a_z  (crd[5]),
        .i_vert_b_x  (crd[6]),
        .i_vert_b_y  (crd[7]),
        .i_vert_b_z  (crd[8]),
        .i_vert_c_x  (crd[9]),
        .i_vert_c_y  (crd[10]),
        .i_vert_c_z  (crd[11]),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_distance  (o_distance),
        .o_region    (o_region)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_vec vsub(t_vec a, t_vec b);
        t_vec r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic t_wide vdot(t_vec a, t_vec b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    function automatic t_vec vcross(t_vec a, t_vec b);
        t_vec r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    function automatic logic [31:0] floor_root(t_wide num, t_wide den);
        logic [31:0] d;
        logic [31:0] t;
        logic [63:0] sq;
        t_wide       w;
        d = '0;
        for (int b = 31; b >= 0; b--) begin
            t = d | (32'd1 << b);
            sq = 64'(t) * 64'(t);
            w = sq;
            if (w * den <= num) d = t;
        end
        return d;
    endfunction

    function automatic void along_edge(t_wide s2, t_wide proj, t_wide len2,
                                       output t_wide num, output t_wide den);
        if (len2 == 0) begin
            num = s2;
            den = 1;
        end else begin
            num = s2 * len2 - proj * proj;
            den = len2;
        end
    endfunction

    function automatic void nearest_feature(t_crd c [12], output logic [31:0] want_d,
                                            output t_region rg);
        t_vec  p, a, b, cc, ab, ac, ap, bp, cp;
        t_wide d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, num, den, fden, s;
        p.x = c[0];  p.y = c[1];  p.z = c[2];
        a.x = c[3];  a.y = c[4];  a.z = c[5];
        b.x = c[6];  b.y = c[7];  b.z = c[8];
        cc.x = c[9]; cc.y = c[10]; cc.z = c[11];
        ab = vsub(b, a);
        ac = vsub(cc, a);
        ap = vsub(p, a);
        bp = vsub(p, b);
        cp = vsub(p, cc);
        d1 = vdot(ab, ap); d2 = vdot(ac, ap);
        d3 = vdot(ab, bp); d4 = vdot(ac, bp);
        d5 = vdot(ab, cp); d6 = vdot(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        e1 = d4 - d3;
        e2 = d5 - d6;
        den = 1;
        if (d1 <= 0 && d2 <= 0) begin
            rg = RG_VERT_A; num = vdot(ap, ap);
        end else if (d3 >= 0 && d4 <= d3) begin
            rg = RG_VERT_B; num = vdot(bp, bp);
        end else if (d6 >= 0 && d5 <= d6) begin
            rg = RG_VERT_C; num = vdot(cp, cp);
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            rg = RG_EDGE_AB; along_edge(vdot(ap, ap), d1, d1 - d3, num, den);
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            rg = RG_EDGE_AC; along_edge(vdot(ap, ap), d2, d2 - d6, num, den);
        end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
            rg = RG_EDGE_BC; along_edge(vdot(bp, bp), e1, e1 + e2, num, den);
        end else begin
            fden = va + vb + vc;
            if (fden <= 0) begin
                rg = RG_DEGEN; num = vdot(ap, ap);
            end else begin
                s = vdot(vcross(ab, ac), ap);
                rg = RG_FACE; num = s * s; den = fden;
            end
        end
        want_d = floor_root(num, den);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH word %0d %s: got %h expected %h", words_checked, what, got, want);
        errors++;
    endtask

    // input side: valid stays high between back-to-back words, with random idle gaps outside the steady stretch
    task automatic send_word(t_crd c [12]);
        logic [31:0] d;
        t_region     rg;
        @(negedge i_clk);
        if (!no_idle && $urandom_range(99) < 3) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        crd = c;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        nearest_feature(c, d, rg);
        exp_dist_q = {exp_dist_q, d};
        exp_region_q = {exp_region_q, rg};
        region_seen[rg]++;
        words_sent++;
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        hold_input();
        while (exp_dist_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_crd rnd_full();
        return t_crd'($urandom);
    endfunction

    function automatic t_crd rnd_scaled(int sh);
        t_crd r;
        r = t_crd'($urandom);
        return r >>> sh;
    endfunction

    task automatic send_tri(t_crd px, t_crd py, t_crd pz, t_crd ax, t_crd ay, t_crd az,
                            t_crd bx, t_crd by, t_crd bz, t_crd cx, t_crd cy, t_crd cz);
        t_crd c [12];
        c = '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
        send_word(c);
    endtask

    task automatic test_regions();
        t_crd f;
        f = ONE;
        send_tri(-f, -f, f,     0, 0, 0,  4*f, 0, 0,  0, 4*f, 0);
        send_tri(5*f, -f, 0,    0, 0, 0,  4*f, 0, 0,  0, 4*f, 0);
        send_tri(-f, 5*f, 0,    0, 0, 0,  4*f, 0, 0,  0, 4*f, 0);
        send_tri(2*f, -f, 3*f,  0, 0, 0,  4*f, 0, 0,  0, 4*f, 0);
        send_tri(-f, 2*f, 0,    0, 0, 0,  4*f, 0, 0,  0, 4*f, 0);
        send_tri(3*f, 3*f, f,   0, 0, 0,  4*f, 0, 0,  0, 4*f, 0);
        send_tri(f, f, 2*f,     0, 0, 0,  4*f, 0, 0,  0, 4*f, 0);
        send_tri(f, f, 0,       0, 0, 0,  4*f, 0, 0,  0, 4*f, 0);
        send_tri(f, f, -5,      0, 0, 0,  4*f, 0, 0,  0, 4*f, 0);
    endtask

    task automatic test_degenerate();
        t_crd f;
        f = ONE;
        send_tri(f, f, f,       0, 0, 0,  2*f, 0, 0,  f, 0, 0);
        send_tri(f, 2*f, 0,     0, 0, 0,  2*f, 0, 0,  4*f, 0, 0);
        send_tri(3*f, f, 0,     f, f, f,  f, f, f,  f, f, f);
        send_tri(f, 3*f, 0,     0, 0, 0,  0, 0, 0,  4*f, 0, 0);
        send_tri(3*f, 3*f, f,   0, 0, 0,  4*f, 0, 0,  4*f, 0, 0);
        send_tri(-f, 2*f, 0,    0, 0, 0,  4*f, 0, 0,  0, 0, 0);
        send_tri(2*f, 2*f, 0,   0, 0, 0,  2*f, 0, 0,  0, 0, 0);
    endtask

    task automatic test_extremes();
        t_crd mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        send_tri(mx, mx, mx,  mx, mx, mx,  mx, mx, mx,  mx, mx, mx);
        send_tri(mn, mn, mn,  mn, mn, mn,  mn, mn, mn,  mn, mn, mn);
        send_tri(mn, mn, mn,  mx, mx, mx,  mx, mn, mx,  mx, mx, mn);
        send_tri(mx, mn, mx,  mn, mx, mn,  mx, mx, mn,  mn, mn, mx);
        send_tri(0, 0, mx,    mn, mn, 0,   mx, mn, 0,   0, mx, 0);
        send_tri(0, 0, 0,     mn, mn, mn,  mx, mx, mx,  mn, mx, mn);
        send_tri(-1, -1, -1,  0, 0, 0,     0, 0, 1,     1, 0, 0);
    endtask

    task automatic test_random(int n, bit full);
        t_crd c [12];
        int   sh;
        for (int i = 0; i < n; i++) begin
            sh = full ? 0 : $urandom_range(18, 4);
            foreach (c[k]) c[k] = full ? rnd_full() : rnd_scaled(sh);
            case ($urandom_range(15))
                0: c[6:8] = c[3:5];
                1: c[9:11] = c[3:5];
                2: c[9:11] = c[6:8];
                3: c[0:2] = c[3:5];
                4: for (int k = 0; k < 3; k++) c[9 + k] = 2 * c[6 + k] - c[3 + k];
                default: ;
            endcase
            send_word(c);
        end
    endtask

    task automatic test_steady();
        no_idle = 1'b1;
        test_random(200, 1'b0);
        no_idle = 1'b0;
    endtask

    // output side: receiver stalls, except in the steady stretch
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= no_idle || ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_dist_q.size() == 0) begin
                report_mismatch("unexpected word", o_distance, '0);
            end else begin
                if (o_distance !== exp_dist_q[0])
                    report_mismatch("distance", o_distance, exp_dist_q[0]);
                if (o_region !== exp_region_q[0])
                    report_mismatch("region", 32'(o_region), 32'(exp_region_q[0]));
                void'(exp_dist_q.pop_front());
                void'(exp_region_q.pop_front());
            end
            words_checked++;
        end
    end

    initial begin
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        foreach (crd[k]) crd[k] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_regions();
        test_degenerate();
        test_extremes();
        wait_drained();
        test_random(500, 1'b0);
        test_steady();
        wait_drained();
        test_random(200, 1'b1);
        test_random(200, 1'b0);
        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("Covered %0d words (%0d checked), per-region counts a/b/c/ab/ac/bc/face/degen:",
                 words_sent, words_checked);
        $display("  %0d %0d %0d %0d %0d %0d %0d %0d", region_seen[0], region_seen[1],
                 region_seen[2], region_seen[3], region_seen[4], region_seen[5],
                 region_seen[6], region_seen[7]);
        if (errors == 0 && exp_dist_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
